>>> sv/ffha_pkg.sv
`timescale 1ns / 1ps
package ffha_pkg;

  localparam int OFF_W  = 25;
  localparam int SIZE_W = 26;

  localparam logic [2:0] ST_DONE       = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE   = 3'd1;
  localparam logic [2:0] ST_NO_FIT     = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL = 3'd3;
  localparam logic [2:0] ST_IGNORED    = 3'd4;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [2:0] CELL_HOLD    = 3'd0;
  localparam logic [2:0] CELL_LOAD_A  = 3'd1;
  localparam logic [2:0] CELL_LOAD_B  = 3'd2;
  localparam logic [2:0] CELL_FROM_LO = 3'd3;
  localparam logic [2:0] CELL_FROM_HI = 3'd4;

  typedef struct packed {
    logic              opcode;
    logic [OFF_W-1:0]  request_bytes;
    logic [OFF_W-1:0]  release_offset;
  } in_t;

  typedef struct packed {
    logic [OFF_W-1:0]  payload_offset;
    logic [2:0]        status;
  } out_t;

  typedef struct packed {
    logic [OFF_W-1:0]  start;
    logic [SIZE_W-1:0] size;
    logic              used;
  } entry_t;

  typedef struct packed {
    logic [2:0] op;
    entry_t     ent_a;
    entry_t     ent_b;
  } cell_ctl_t;

endpackage

>>> sv/ffha_cell.sv
`timescale 1ns / 1ps
module ffha_cell
  import ffha_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  entry_t    init_val,
  input  cell_ctl_t ctl,
  input  entry_t    from_lo,
  input  entry_t    from_hi,
  output entry_t    ent
);

  entry_t ent_r;
  entry_t ent_nxt;

  always_comb begin
    case (ctl.op)
      CELL_HOLD:    ent_nxt = ent_r;
      CELL_LOAD_A:  ent_nxt = ctl.ent_a;
      CELL_LOAD_B:  ent_nxt = ctl.ent_b;
      CELL_FROM_LO: ent_nxt = from_lo;
      CELL_FROM_HI: ent_nxt = from_hi;
      default:      ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= init_val;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign ent = ent_r;

endmodule

>>> sv/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// First-fit heap allocator. The block table lives in a chain of MAX_BLOCKS cells in
// address order; a split shifts the upper cells up one place and a merge shifts them
// down. A request is scanned one table entry per cycle from the lowest address; an
// allocate stops at the first entry that fits, and a release that frees a block goes
// on to two merge steps, one with each neighbor. Bad sizes are answered without a
// table scan. One transaction is in work at a time; the result register lets the
// next request enter while a result waits to be taken.
module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int HEAP_BYTES   = 33554432,
  parameter int HEADER_BYTES = 16,
  parameter int MAX_BLOCKS   = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_MPREV = 3'd2;
  localparam logic [2:0] S_MNEXT = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  localparam logic [SIZE_W:0]   HDR   = (SIZE_W+1)'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] HEAPS = SIZE_W'(HEAP_BYTES);

  logic [2:0]        state_r, state_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [IW-1:0]     hit_r, hit_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              op_r;
  logic [SIZE_W-1:0] need_r;
  logic [OFF_W-1:0]  off_r;
  logic [2:0]        res_st_r, res_st_nxt;
  logic [OFF_W-1:0]  res_off_r, res_off_nxt;
  out_t              out_r;
  logic              out_valid_r;

  entry_t            ents [MAX_BLOCKS];
  entry_t            cur_r, oth_r;
  logic [IW-1:0]     rd_a, rd_b;
  entry_t            cur, prv, nxt;
  logic [1:0]        cmd;
  logic [CW-1:0]     cmd_idx;
  entry_t            ent_a, ent_b;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_SPLIT = 2'd2;
  localparam logic [1:0] CMD_MERGE = 2'd3;

  logic [SIZE_W-1:0] need_in;
  logic              accept;
  logic              last;
  logic              fits;
  logic              hit_ok;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign need_in  = SIZE_W'(in_data.request_bytes) + SIZE_W'(HEADER_BYTES);

  // Table reads are registered: port A fetches the entry the next cycle works on,
  // port B its lower neighbor, or the upper neighbor of the freed entry for the
  // second merge step.
  assign rd_a = idx_nxt;
  assign rd_b = (state_r == S_MPREV) ? hit_r + IW'(1) : idx_nxt - IW'(1);

  assign cur = cur_r;
  assign prv = oth_r;
  assign nxt = oth_r;

  assign last   = (CW'(idx_r) + CW'(1)) >= count_r;
  assign fits   = !cur.used && (cur.size >= need_r);
  assign hit_ok = (SIZE_W'(cur.start) + SIZE_W'(HEADER_BYTES)) == SIZE_W'(off_r);

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    hit_nxt     = hit_r;
    count_nxt   = count_r;
    res_st_nxt  = res_st_r;
    res_off_nxt = res_off_r;
    cmd         = CMD_NONE;
    cmd_idx     = CW'(idx_r);
    ent_a       = cur;
    ent_b       = cur;
    case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (accept) begin
          res_off_nxt = '0;
          if (in_data.opcode == OP_ALLOC &&
              (in_data.request_bytes == '0 || need_in >= HEAPS)) begin
            res_st_nxt = ST_BAD_SIZE;
            state_nxt  = S_RESP;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (op_r == OP_ALLOC) begin
          if (fits) begin
            if ({1'b0, cur.size} > ({1'b0, need_r} + HDR)) begin
              if (count_r >= CW'(MAX_BLOCKS)) begin
                res_st_nxt = ST_TABLE_FULL;
              end else begin
                cmd         = CMD_SPLIT;
                ent_a       = '{start: cur.start, size: need_r, used: 1'b1};
                ent_b       = '{start: cur.start + OFF_W'(need_r),
                                size: cur.size - need_r, used: 1'b0};
                count_nxt   = count_r + CW'(1);
                res_st_nxt  = ST_DONE;
                res_off_nxt = cur.start + OFF_W'(HEADER_BYTES);
              end
            end else begin
              cmd         = CMD_SET;
              ent_a       = '{start: cur.start, size: cur.size, used: 1'b1};
              res_st_nxt  = ST_DONE;
              res_off_nxt = cur.start + OFF_W'(HEADER_BYTES);
            end
            state_nxt = S_RESP;
          end else if (last) begin
            res_st_nxt = ST_NO_FIT;
            state_nxt  = S_RESP;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end else begin
          if (hit_ok) begin
            if (cur.used) begin
              cmd        = CMD_SET;
              ent_a      = '{start: cur.start, size: cur.size, used: 1'b0};
              hit_nxt    = idx_r;
              res_st_nxt = ST_DONE;
              state_nxt  = S_MPREV;
            end else begin
              res_st_nxt = ST_IGNORED;
              state_nxt  = S_RESP;
            end
          end else if (last) begin
            res_st_nxt = ST_IGNORED;
            state_nxt  = S_RESP;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
      end
      S_MPREV: begin
        // hit_r points at the freed entry; cur still holds its start and size.
        if (hit_r != '0 && !prv.used) begin
          cmd       = CMD_MERGE;
          cmd_idx   = CW'(hit_r) - CW'(1);
          ent_a     = '{start: prv.start, size: prv.size + cur.size, used: 1'b0};
          count_nxt = count_r - CW'(1);
          hit_nxt   = hit_r - IW'(1);
          idx_nxt   = hit_r - IW'(1);
        end
        state_nxt = S_MNEXT;
      end
      S_MNEXT: begin
        if ((CW'(hit_r) + CW'(1)) < count_r && !nxt.used) begin
          cmd       = CMD_MERGE;
          cmd_idx   = CW'(hit_r);
          ent_a     = '{start: cur.start, size: cur.size + nxt.size, used: 1'b0};
          count_nxt = count_r - CW'(1);
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    cell_ctl_t ctl;
    entry_t    init_val;
    entry_t    from_lo;
    entry_t    from_hi;

    if (k == 0) begin : g_lo0
      assign init_val = '{start: '0, size: HEAPS, used: 1'b0};
      assign from_lo  = '0;
    end else begin : g_lo
      assign init_val = '0;
      assign from_lo  = ents[k-1];
    end
    if (k == MAX_BLOCKS - 1) begin : g_hiN
      assign from_hi = '0;
    end else begin : g_hi
      assign from_hi = ents[k+1];
    end

    always_comb begin
      ctl.ent_a = ent_a;
      ctl.ent_b = ent_b;
      ctl.op    = CELL_HOLD;
      case (cmd)
        CMD_SET: begin
          if (CW'(k) == cmd_idx) ctl.op = CELL_LOAD_A;
        end
        CMD_SPLIT: begin
          if (CW'(k) == cmd_idx) ctl.op = CELL_LOAD_A;
          else if (CW'(k) == cmd_idx + CW'(1)) ctl.op = CELL_LOAD_B;
          else if (CW'(k) > cmd_idx) ctl.op = CELL_FROM_LO;
        end
        CMD_MERGE: begin
          if (CW'(k) == cmd_idx) ctl.op = CELL_LOAD_A;
          else if (CW'(k) > cmd_idx) ctl.op = CELL_FROM_HI;
        end
        default: ctl.op = CELL_HOLD;
      endcase
    end

    ffha_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .init_val (init_val),
      .ctl      (ctl),
      .from_lo  (from_lo),
      .from_hi  (from_hi),
      .ent      (ents[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= CW'(1);
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      hit_r       <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      hit_r   <= hit_nxt;
      if (state_r == S_RESP && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_st_r  <= res_st_nxt;
    res_off_r <= res_off_nxt;
    oth_r     <= ents[rd_b];
    // After the first merge step the surviving entry is the merged one.
    if (state_r == S_MPREV) begin
      if (cmd == CMD_MERGE) begin
        cur_r <= ent_a;
      end
    end else begin
      cur_r <= ents[rd_a];
    end
    if (accept) begin
      op_r   <= in_data.opcode;
      need_r <= need_in;
      off_r  <= in_data.release_offset;
    end
    if (state_r == S_RESP && (!out_valid_r || out_ready)) begin
      out_r.payload_offset <= res_off_r;
      out_r.status         <= res_st_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> sv/ffha_checker.sv
`timescale 1ns / 1ps
module ffha_checker
  import ffha_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_IGNORED)
    else $error("status code out of range");

  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_DONE |-> out_data.payload_offset == '0)
    else $error("payload offset set on a failed transaction");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while one is in work");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> bench/tb_first_fit_heap_allocator.sv
`timescale 1ns / 1ps
module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  localparam int HEAP  = 33554432;
  localparam int HDR   = 16;
  localparam int MAXB  = 64;
  localparam int STALL_LIMIT = 20000;

  // Scoreboard: an allocator table mirror plus a queue of expected results.
  class heap_scoreboard;
    logic [OFF_W-1:0]  tbl_start[MAXB];
    logic [SIZE_W-1:0] tbl_size[MAXB];
    bit                tbl_used[MAXB];
    int                tbl_count;
    out_t              pending[$];
    int                mismatches;

    function void clear();
      for (int k = 0; k < MAXB; k++) begin
        tbl_start[k] = '0;
        tbl_size[k] = '0;
        tbl_used[k] = 0;
      end
      tbl_size[0] = SIZE_W'(HEAP);
      tbl_count = 1;
      mismatches = 0;
    endfunction

    function void remove_entry(int idx);
      for (int k = idx; k + 1 < tbl_count; k++) begin
        tbl_start[k] = tbl_start[k+1];
        tbl_size[k] = tbl_size[k+1];
        tbl_used[k] = tbl_used[k+1];
      end
      tbl_count--;
      tbl_start[tbl_count] = '0;
      tbl_size[tbl_count] = '0;
      tbl_used[tbl_count] = 0;
    endfunction

    function out_t allocate(longint req);
      out_t r;
      longint need;
      need = req + HDR;
      r = '0;
      r.status = ST_NO_FIT;
      if (req == 0 || need >= HEAP) begin
        r.status = ST_BAD_SIZE;
        return r;
      end
      for (int i = 0; i < tbl_count; i++) begin
        if (tbl_used[i] || longint'(tbl_size[i]) < need) continue;
        if (longint'(tbl_size[i]) > need + HDR) begin
          if (tbl_count >= MAXB) begin
            r.status = ST_TABLE_FULL;
            return r;
          end
          for (int k = tbl_count; k > i + 1; k--) begin
            tbl_start[k] = tbl_start[k-1];
            tbl_size[k] = tbl_size[k-1];
            tbl_used[k] = tbl_used[k-1];
          end
          tbl_start[i+1] = OFF_W'(longint'(tbl_start[i]) + need);
          tbl_size[i+1] = SIZE_W'(longint'(tbl_size[i]) - need);
          tbl_used[i+1] = 0;
          tbl_size[i] = SIZE_W'(need);
          tbl_count++;
        end
        tbl_used[i] = 1;
        r.payload_offset = OFF_W'(longint'(tbl_start[i]) + HDR);
        r.status = ST_DONE;
        return r;
      end
      return r;
    endfunction

    function out_t release_block(longint off);
      out_t r;
      int hit;
      r = '0;
      r.status = ST_IGNORED;
      hit = -1;
      for (int i = 0; i < tbl_count; i++)
        if (longint'(tbl_start[i]) + HDR == off) begin
          hit = i;
          break;
        end
      if (hit < 0 || !tbl_used[hit]) return r;
      tbl_used[hit] = 0;
      if (hit > 0 && !tbl_used[hit-1]) begin
        tbl_size[hit-1] = tbl_size[hit-1] + tbl_size[hit];
        remove_entry(hit);
        hit--;
      end
      if (hit + 1 < tbl_count && !tbl_used[hit+1]) begin
        tbl_size[hit] = tbl_size[hit] + tbl_size[hit+1];
        remove_entry(hit + 1);
      end
      r.status = ST_DONE;
      return r;
    endfunction

    function void note_request(in_t t);
      if (t.opcode == OP_ALLOC) pending.push_back(allocate(t.request_bytes));
      else pending.push_back(release_block(t.release_offset));
    endfunction

    function bit check_result(out_t got);
      out_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return 0;
      end
      exp = pending.pop_front();
      if (got.payload_offset !== exp.payload_offset || got.status !== exp.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected offset %0d status %0d, got offset %0d status %0d",
                   exp.payload_offset, exp.status, got.payload_offset, got.status);
        return 0;
      end
      return 1;
    endfunction
  endclass

  logic clk, rst_n, in_valid, in_ready, out_valid, out_ready;
  in_t  in_data;
  out_t out_data;

  heap_scoreboard sb;
  logic [OFF_W-1:0] granted[$];
  int  idle_cycles;
  bit  stim_done;
  bit  hold_off_req;
  bit  fast_sender;

  first_fit_heap_allocator dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // Scoreboard update and offset bookkeeping happen on the accepting edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_request(in_data);
    if (rst_n && out_valid && out_ready) begin
      void'(sb.check_result(out_data));
      if (out_data.status == ST_DONE && out_data.payload_offset != 0)
        granted.push_back(out_data.payload_offset);
    end
  end

  task automatic send(input logic op, input logic [OFF_W-1:0] req,
                      input logic [OFF_W-1:0] off);
    in_t t;
    int g;
    t.opcode = op;
    t.request_bytes = req;
    t.release_offset = off;
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
    g = fast_sender ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_alloc(input logic [OFF_W-1:0] req);
    send(OP_ALLOC, req, OFF_W'($urandom));
  endtask

  task automatic send_release(input logic [OFF_W-1:0] off);
    send(OP_RELEASE, OFF_W'($urandom), off);
  endtask

  function logic [OFF_W-1:0] pick_granted();
    int k;
    logic [OFF_W-1:0] v;
    if (granted.size() == 0) return OFF_W'(HDR);
    k = $urandom_range(0, granted.size() - 1);
    v = granted[k];
    granted.delete(k);
    return v;
  endfunction

  function logic [OFF_W-1:0] rand_size();
    case ($urandom_range(0, 9))
      0: return OFF_W'($urandom);
      1: return OFF_W'($urandom_range(1, 4));
      2: return OFF_W'($urandom_range(1 << 20, 1 << 23));
      default: return OFF_W'($urandom_range(1, 3000));
    endcase
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int g;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off_req = 0;
      end
      g = gap_len();
      out_ready <= (g == 0);
      @(posedge clk);
      if (g > 1) repeat (g - 1) @(posedge clk);
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int tail;
    sb = new();
    sb.clear();
    stim_done = 0;
    hold_off_req = 0;
    fast_sender = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: size edges, exact fit, split, merges, bad releases.
    send_alloc('0);
    send_alloc(OFF_W'(HEAP - HDR));
    send_alloc(OFF_W'(HEAP - HDR - 1));
    send_release(OFF_W'(HDR));
    send_release(OFF_W'(HDR));
    send_alloc(OFF_W'(HEAP - HDR - 1));
    send_alloc(OFF_W'(1));
    send_alloc('1);
    send_release('0);
    send_release('1);
    send_alloc(OFF_W'(100));
    send_alloc(OFF_W'(200));
    send_alloc(OFF_W'(300));
    send_release(OFF_W'(HDR + 116));
    send_release(OFF_W'(HDR + 116));
    send_release(OFF_W'(HDR));
    send_release(OFF_W'(HDR + 332));
    send_alloc(OFF_W'(100));
    send_release(OFF_W'(HDR));

    // Fill the table with small blocks while the receiver holds off.
    hold_off_req = 1;
    fast_sender = 1;
    repeat (70) send_alloc(OFF_W'($urandom_range(1, 64)));
    fast_sender = 0;
    repeat (2) send_alloc(OFF_W'(HEAP / 2));
    send_alloc(OFF_W'(8));
    repeat (20) send_release(pick_granted());
    repeat (10) send_alloc(OFF_W'($urandom_range(1, 40)));

    for (int n = 0; n < 1030; n++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8: send_alloc(rand_size());
        9, 10, 11, 12, 13, 14, 15, 16: send_release(pick_granted());
        17: send_release(OFF_W'($urandom));
        18: send(OP_RELEASE, OFF_W'($urandom), OFF_W'(HDR + 16 * $urandom_range(0, 200)));
        default: send_alloc(OFF_W'($urandom_range(0, 1) ? 0 : HEAP - HDR));
      endcase
    end
    in_valid <= 1'b0;
    stim_done = 1;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
